// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define MET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define MET_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Checked through reset as well.
`define MET_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/met_pkg.sv =====
// Shared types and constants for the Mandelbrot escape-time pixel block.
// No dependencies.
package met_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int ORIGIN_BITS    = 32;
    localparam int STEP_BITS      = 31;
    localparam int LIMIT_BITS     = 16;
    localparam int SHADE_BITS     = 8;
    localparam int DIV_BITS       = SHADE_BITS + LIMIT_BITS;
    localparam int DIV_STEP_BITS  = $clog2(SHADE_BITS);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_REAL_ORIGIN     = 3'd0,
        CFG_IMAG_ORIGIN     = 3'd1,
        CFG_REAL_STEP       = 3'd2,
        CFG_IMAG_STEP       = 3'd3,
        CFG_ITERATION_LIMIT = 3'd4,
        CFG_COLOUR_SCALE    = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [ORIGIN_BITS-1:0] real_origin;
        logic [ORIGIN_BITS-1:0] imag_origin;
        logic [STEP_BITS-1:0]   real_step;
        logic [STEP_BITS-1:0]   imag_step;
        logic [LIMIT_BITS-1:0]  iteration_limit;
        logic [SHADE_BITS-1:0]  colour_scale;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        real_origin:     32'hE000_0000,
        imag_origin:     32'hEC00_0000,
        real_step:       31'd655360,
        imag_step:       31'd655360,
        iteration_limit: 16'd200,
        colour_scale:    8'd255
    };

    typedef struct packed {
        logic                  start;
        logic [LIMIT_BITS-1:0] count;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [SHADE_BITS-1:0] shade;
    } t_div_rsp;

endpackage

// ===== hdl/mandelbrot_escape_time_pixel.sv =====
// Top level of the Mandelbrot escape-time pixel block: configuration registers,
// front end, queue, iteration core and shade divider. Depends on met_pkg and its modules.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------
//  pixel   | in        | i_in_valid / o_in_stall    | i_real_index, i_imag_index
//  shade   | out       | o_out_valid / i_out_stall  | o_shade
//  config  | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  One pixel holds the core through the idle state, the loop passes (at most iteration_limit
//  iterations run; each pass a multiply state and then, unless the loop stops there, an update
//  state; the loop also ends when |z|^2 reaches 4), the shade divider (eight quotient bits and
//  done) and the writeback state. A pixel reaches the core through the front stage and queue.
//  Reset is synchronous and active low; it loads the register defaults and empties
//  the pipeline. Pixels are taken while the front stage or the two-entry queue has room,
//  so a stalled shade output stops the core but not the front end until the queue fills.
module mandelbrot_escape_time_pixel #(
    parameter int INDEX_BITS = 12,
    parameter int FRAC_BITS  = 28
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [INDEX_BITS-1:0]              i_real_index,
    input  logic [INDEX_BITS-1:0]              i_imag_index,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [met_pkg::SHADE_BITS-1:0]     o_shade,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [met_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [met_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int CW = INDEX_BITS + met_pkg::STEP_BITS + 2;

    met_pkg::t_cfg     r_cfg;
    met_pkg::t_div_req w_div_req;
    met_pkg::t_div_rsp w_div_rsp;
    logic              w_push, w_full, w_pop, w_empty;
    logic [CW-1:0]     w_push_real, w_push_imag;
    logic [2*CW-1:0]   w_pop_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= met_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (met_pkg::t_cfg_index'(i_cfg_index))
                met_pkg::CFG_REAL_ORIGIN:     r_cfg.real_origin     <= i_cfg_data;
                met_pkg::CFG_IMAG_ORIGIN:     r_cfg.imag_origin     <= i_cfg_data;
                met_pkg::CFG_REAL_STEP:
                    r_cfg.real_step <= i_cfg_data[met_pkg::STEP_BITS-1:0];
                met_pkg::CFG_IMAG_STEP:
                    r_cfg.imag_step <= i_cfg_data[met_pkg::STEP_BITS-1:0];
                met_pkg::CFG_ITERATION_LIMIT:
                    r_cfg.iteration_limit <= i_cfg_data[met_pkg::LIMIT_BITS-1:0];
                met_pkg::CFG_COLOUR_SCALE:
                    r_cfg.colour_scale <= i_cfg_data[met_pkg::SHADE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    met_front #(
        .INDEX_BITS (INDEX_BITS),
        .CW         (CW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_real_index (i_real_index),
        .i_imag_index (i_imag_index),
        .o_push       (w_push),
        .o_point_real (w_push_real),
        .o_point_imag (w_push_imag),
        .i_queue_full (w_full)
    );

    met_queue #(
        .WIDTH (2 * CW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data ({w_push_imag, w_push_real}),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_empty     (w_empty)
    );

    met_core #(
        .FRAC_BITS (FRAC_BITS),
        .CW        (CW)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_empty    (w_empty),
        .o_q_pop      (w_pop),
        .i_point_real (w_pop_data[CW-1:0]),
        .i_point_imag (w_pop_data[2*CW-1:CW]),
        .o_div_req    (w_div_req),
        .i_div_rsp    (w_div_rsp),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_shade      (o_shade)
    );

    met_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

endmodule

// ===== hdl/met_queue.sv =====
// Two-entry queue between the coordinate front end and the iteration core.
// Depends on nothing but its WIDTH parameter.
module met_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_pop_data,
    output logic             o_empty
);

    logic             r_head_valid, r_tail_valid;
    logic             n_head_valid, n_tail_valid;
    logic [WIDTH-1:0] r_head, r_tail;
    logic [WIDTH-1:0] n_head, n_tail;

    assign o_full     = r_tail_valid;
    assign o_empty    = !r_head_valid;
    assign o_pop_data = r_head;

    always_comb begin
        n_head_valid = r_head_valid;
        n_tail_valid = r_tail_valid;
        n_head       = r_head;
        n_tail       = r_tail;
        if (i_pop) begin
            if (r_tail_valid) begin
                // advance tail into head, refill tail on a push
                n_head       = r_tail;
                n_tail_valid = i_push;
                n_tail       = i_push_data;
            end else begin
                n_head_valid = i_push;
                n_head       = i_push_data;
            end
        end else if (i_push) begin
            if (!r_head_valid) begin
                n_head_valid = 1'b1;
                n_head       = i_push_data;
            end else begin
                n_tail_valid = 1'b1;
                n_tail       = i_push_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_tail_valid <= 1'b0;
        end else begin
            r_head_valid <= n_head_valid;
            r_tail_valid <= n_tail_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_tail <= n_tail;
    end

endmodule

// ===== hdl/met_div.sv =====
// Shade divider: floor(colour_scale * count / iteration_limit), one quotient bit a cycle.
// Depends on met_pkg for the configuration and request/response types.
module met_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  met_pkg::t_cfg     i_cfg,
    input  met_pkg::t_div_req i_req,
    output met_pkg::t_div_rsp o_rsp
);

    localparam int DW = met_pkg::DIV_BITS;
    localparam int QW = met_pkg::SHADE_BITS;
    localparam int KW = met_pkg::DIV_STEP_BITS;

    logic                            r_busy;
    logic                            r_done;
    logic [KW-1:0]                   r_step;
    logic [DW-1:0]                   r_rem;
    logic [met_pkg::LIMIT_BITS-1:0]  r_den;
    logic [QW-1:0]                   r_quo;
    logic                            r_zero;
    logic [DW-1:0]                   w_trial;
    logic                            w_fits;

    // quotient is below 2^QW since count never exceeds the limit
    assign w_trial = DW'(r_den) << r_step;
    assign w_fits  = r_rem >= w_trial;

    assign o_rsp.done  = r_done;
    assign o_rsp.shade = r_zero ? '0 : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && (r_step == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= KW'(QW - 1);
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= DW'(i_cfg.colour_scale) * DW'(i_req.count);
            r_den  <= i_cfg.iteration_limit;
            r_zero <= i_cfg.iteration_limit == '0;
            r_quo  <= '0;
        end else if (r_busy && w_fits) begin
            r_rem         <= r_rem - w_trial;
            r_quo[r_step] <= 1'b1;
        end
    end

endmodule

// ===== hdl/met_front.sv =====
// Front end: accepts a pixel's grid indices and forms the point c for the queue.
// Depends on met_pkg for the configuration type and field widths.
module met_front #(
    parameter int INDEX_BITS = 12,
    parameter int CW         = 45
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  met_pkg::t_cfg         i_cfg,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [INDEX_BITS-1:0] i_real_index,
    input  logic [INDEX_BITS-1:0] i_imag_index,
    output logic                  o_push,
    output logic [CW-1:0]         o_point_real,
    output logic [CW-1:0]         o_point_imag,
    input  logic                  i_queue_full
);

    localparam int PW = INDEX_BITS + met_pkg::STEP_BITS;

    logic          r_valid;
    logic          n_valid;
    logic          w_accept;
    logic [PW-1:0] r_real_prod, r_imag_prod;

    assign o_stall  = r_valid && i_queue_full;
    assign w_accept = i_valid && !o_stall;
    assign o_push   = r_valid && !i_queue_full;

    assign o_point_real = CW'($signed(i_cfg.real_origin)) + CW'(r_real_prod);
    assign o_point_imag = CW'($signed(i_cfg.imag_origin)) + CW'(r_imag_prod);

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_real_prod <= PW'(i_real_index) * PW'(i_cfg.real_step);
            r_imag_prod <= PW'(i_imag_index) * PW'(i_cfg.imag_step);
        end
    end

endmodule

// ===== hdl/met_core.sv =====
// Iteration core: runs z = z^2 + c for one point, hands the count to the divider,
// and holds the finished shade in the output register. Depends on met_pkg.
module met_core #(
    parameter int FRAC_BITS = 28,
    parameter int CW        = 45
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  met_pkg::t_cfg                  i_cfg,
    input  logic                           i_q_empty,
    output logic                           o_q_pop,
    input  logic [CW-1:0]                  i_point_real,
    input  logic [CW-1:0]                  i_point_imag,
    output met_pkg::t_div_req              o_div_req,
    input  met_pkg::t_div_rsp              i_div_rsp,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [met_pkg::SHADE_BITS-1:0] o_shade
);

    localparam int XW  = FRAC_BITS + 2;
    localparam int PRW = 2 * XW;
    localparam int SQW = 2 * FRAC_BITS + 2;
    localparam int SW  = CW + 1;
    localparam logic signed [SW-1:0] P_TWO     = SW'(1) <<< (FRAC_BITS + 1);
    localparam logic signed [SW-1:0] P_NEG_TWO = -P_TWO;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_UPD  = 5'b00100,
        S_DIV  = 5'b01000,
        S_WB   = 5'b10000
    } t_state;

    t_state                           r_state, n_state;
    logic                             r_big, n_big;
    logic [met_pkg::LIMIT_BITS-1:0]   r_count, n_count;
    logic                             r_out_valid, n_out_valid;
    logic signed [CW-1:0]             r_cx, r_cy;
    logic signed [XW-1:0]             r_x, r_y;
    logic [SQW-1:0]                   r_xx, r_yy;
    logic signed [PRW-1:0]            r_xy;
    logic [met_pkg::SHADE_BITS-1:0]   r_shade;

    logic signed [PRW-1:0] w_xx_full, w_yy_full, w_xy_full;
    logic [SQW:0]          w_mag2;
    logic                  w_escape;
    logic signed [SQW+1:0] w_diff;
    logic signed [SW-1:0]  w_nx, w_ny;
    logic                  w_next_big;
    logic                  w_stop;
    logic                  w_out_free;

    assign w_xx_full = r_x * r_x;
    assign w_yy_full = r_y * r_y;
    assign w_xy_full = r_x * r_y;

    // squares are below 2^SQW while |x|, |y| < 2
    assign w_mag2   = {1'b0, r_xx} + {1'b0, r_yy};
    assign w_escape = w_mag2[SQW];
    assign w_diff   = $signed({2'b00, r_xx}) - $signed({2'b00, r_yy});
    assign w_nx     = SW'(w_diff >>> FRAC_BITS) + SW'(r_cx);
    assign w_ny     = SW'(r_xy >>> (FRAC_BITS - 1)) + SW'(r_cy);
    assign w_next_big = (w_nx >= P_TWO) || (w_nx <= P_NEG_TWO)
                     || (w_ny >= P_TWO) || (w_ny <= P_NEG_TWO);

    assign w_stop     = (r_count >= i_cfg.iteration_limit) || r_big;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_q_pop         = (r_state == S_IDLE) && !i_q_empty;
    assign o_div_req.start = ((r_state == S_MUL) && w_stop) || ((r_state == S_UPD) && w_escape);
    assign o_div_req.count = r_count;
    assign o_out_valid     = r_out_valid;
    assign o_shade         = r_shade;

    always_comb begin
        n_state     = r_state;
        n_big       = r_big;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = S_MUL;
                    n_big   = 1'b0;
                    n_count = '0;
                end
            end
            S_MUL: begin
                n_state = w_stop ? S_DIV : S_UPD;
            end
            S_UPD: begin
                if (w_escape) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_MUL;
                    n_big   = w_next_big;
                    n_count = r_count + 1'b1;
                end
            end
            S_DIV: begin
                if (i_div_rsp.done) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                // hold the shade in the divider until the output slot frees up
                if (w_out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_big       <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_big       <= n_big;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cx <= $signed(i_point_real);
            r_cy <= $signed(i_point_imag);
            r_x  <= '0;
            r_y  <= '0;
        end else if ((r_state == S_UPD) && !w_escape) begin
            // drop the upper bits: when they matter the point has escaped
            r_x <= w_nx[XW-1:0];
            r_y <= w_ny[XW-1:0];
        end
        if (r_state == S_MUL) begin
            r_xx <= w_xx_full[SQW-1:0];
            r_yy <= w_yy_full[SQW-1:0];
            r_xy <= w_xy_full;
        end
        if ((r_state == S_WB) && w_out_free) begin
            r_shade <= i_div_rsp.shade;
        end
    end

endmodule

// ===== hdl/met_checker.sv =====
// Port-level checks for the Mandelbrot escape-time pixel block, bound to its top level.
// Depends on assert_macros.svh and met_pkg.
`include "assert_macros.svh"

module met_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [met_pkg::SHADE_BITS-1:0] o_shade,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready
);

    `MET_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "shade dropped while stalled")
    `MET_ASSERT_NEXT(a_shade_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_shade), "shade changed while stalled")
    `MET_ASSERT_ALWAYS_NEXT(a_reset_empty, i_clk, !i_rst_n, !o_out_valid && !o_in_stall, "pipeline not empty after reset")
    `MET_ASSERT_SAME(a_cfg_no_wait, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready, "config write held off")

endmodule

bind mandelbrot_escape_time_pixel met_checker u_met_checker (.*);
